FILE: design/mlfr_pkg.sv
// Shared types, constants and the CRC step of the location frame receiver.
`timescale 1ns / 1ps
package mlfr_pkg;

	localparam int BUF_DEPTH    = 128;
	localparam int ANCHOR_COUNT = 16;
	localparam int STAMP_COUNT  = 6;
	localparam int AW           = $clog2(BUF_DEPTH);
	localparam int PW           = AW + 1;
	localparam int LW           = (PW > 9) ? PW : 9;
	localparam int RQ_DEPTH     = 4;

	localparam logic [2:0] K_START = 3'd0;
	localparam logic [2:0] K_STOP  = 3'd1;
	localparam logic [2:0] K_CRC   = 3'd2;
	localparam logic [2:0] K_LONG  = 3'd3;
	localparam logic [2:0] K_FIELD = 3'd4;
	localparam logic [2:0] K_POS   = 3'd5;
	localparam logic [2:0] K_TRUNC = 3'd6;

	localparam logic [4:0] F_IND    = 5'd0;
	localparam logic [4:0] F_TAG    = 5'd1;
	localparam logic [4:0] F_STATUS = 5'd2;
	localparam logic [4:0] F_X      = 5'd3;
	localparam logic [4:0] F_DIST   = 5'd6;
	localparam logic [4:0] F_DIAG   = 5'd7;
	localparam logic [4:0] F_STAMP  = 5'd15;
	localparam logic [4:0] F_DFLAGS = 5'd16;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] MB_ADDR  = 8'h01;
	localparam logic [7:0] MB_FUNC  = 8'h03;
	localparam logic [7:0] TY_ANC   = 8'hCA;
	localparam logic [7:0] TY_TAG   = 8'hAC;
	localparam logic [7:0] TY_LOW   = 8'hDA;

	typedef enum logic [1:0] {J_START, J_STOP, J_LONG, J_FRAME} job_kind_t;
	typedef enum logic [1:0] {FT_NONE, FT_ANCHOR, FT_TAG} ftype_t;

	typedef struct packed {
		job_kind_t       jk;
		logic [PW-1:0]   flen;
		ftype_t          ft;
	} job_t;

	typedef struct packed {
		logic            en;
		logic [AW-1:0]   addr;
		logic [7:0]      data;
	} wr_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic               source;
		logic [4:0]         field_code;
		logic [3:0]         item_index;
		logic [31:0]        value;
		logic signed [15:0] report_x;
		logic signed [15:0] report_y;
		logic               last;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
		end
		return r;
	endfunction

endpackage

FILE: design/mlfr_front.sv
// Front end: stores bytes, tracks the header and issues a job per frame or command.
`timescale 1ns / 1ps
module mlfr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     rx_byte,
	input  logic           job_take,
	output mlfr_pkg::wr_t  wr,
	output logic           job_valid,
	output mlfr_pkg::job_t job
);
	import mlfr_pkg::*;

	logic [PW-1:0] fill_q;
	logic [7:0]    s_q [5];
	logic [7:0]    s_n [5];
	logic [PW-1:0] f;
	logic [PW-1:0] nf;
	logic [LW-1:0] flen;
	logic          is_p;
	logic          is_mb;
	ftype_t        ft;
	logic          job_valid_q;
	job_t          job_q;

	always_comb begin
		f  = (fill_q >= PW'(BUF_DEPTH)) ? '0 : fill_q;
		nf = f + PW'(1);
		for (int k = 0; k < 5; k++) begin
			s_n[k] = (f == PW'(k)) ? rx_byte : s_q[k];
		end
		flen  = LW'(s_n[2]) + LW'(5);
		is_p  = s_n[0] == CH_P && s_n[1] == CH_G && s_n[2] == CH_S && s_n[3] == CH_T;
		is_mb = s_n[0] == MB_ADDR && s_n[1] == MB_FUNC;
		if (s_n[3] == TY_ANC && s_n[4] == TY_LOW) begin
			ft = FT_ANCHOR;
		end else if (s_n[3] == TY_TAG && s_n[4] == TY_LOW) begin
			ft = FT_TAG;
		end else begin
			ft = FT_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 5; k++) begin
				s_q[k] <= s_n[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			job_valid_q <= 1'b0;
			job_q       <= '0;
		end else begin
			if (job_take) begin
				job_valid_q <= 1'b0;
			end
			if (accept) begin
				fill_q <= nf;
				if (nf >= PW'(5)) begin
					if (is_p && s_n[4] == CH_A) begin
						job_valid_q <= 1'b1;
						job_q       <= '{jk: J_START, flen: '0, ft: FT_NONE};
						fill_q      <= '0;
					end else if (is_p && s_n[4] == CH_O) begin
						job_valid_q <= 1'b1;
						job_q       <= '{jk: J_STOP, flen: '0, ft: FT_NONE};
						fill_q      <= '0;
					end else if (is_mb) begin
						if (flen > LW'(BUF_DEPTH)) begin
							job_valid_q <= 1'b1;
							job_q       <= '{jk: J_LONG, flen: '0, ft: FT_NONE};
							fill_q      <= '0;
						end else if (LW'(nf) >= flen) begin
							job_valid_q <= 1'b1;
							job_q       <= '{jk: J_FRAME, flen: flen[PW-1:0], ft: ft};
							fill_q      <= '0;
						end
					end else begin
						fill_q <= '0;
					end
				end
			end
		end
	end

	assign wr        = '{en: accept, addr: f[AW-1:0], data: rx_byte};
	assign job_valid = job_valid_q;
	assign job       = job_q;

endmodule

FILE: design/mlfr_back.sv
// Back end: frame memory, CRC check and the field decode sequencer.
`timescale 1ns / 1ps
module mlfr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mlfr_pkg::wr_t     wr,
	input  logic              job_valid,
	input  mlfr_pkg::job_t    job,
	input  logic [15:0]       watched_tag_id,
	input  logic              fifo_full,
	output logic              job_take,
	output logic              busy,
	output logic              res_push,
	output mlfr_pkg::result_t res
);
	import mlfr_pkg::*;

	typedef enum logic [2:0] {B_IDLE, B_CRC, B_FETCH, B_PLAN, B_USE, B_FLUSH} bstate_t;
	typedef enum logic [4:0] {
		P_SIMPLE, P_TRUNC, P_CRCV,
		A_IND, A_TAG, A_FLAGS, A_POS, A_XYZ, A_DSEC, A_DIST, A_GSEC, A_DIAG, A_SSEC, A_STAMP,
		T_IND, T_FSEC, T_FLAGS, T_DIST, T_PSEC, T_STAT, T_XYZ, T_REP
	} phase_t;

	logic [7:0] mem [BUF_DEPTH];
	logic [7:0] rdata_q;
	logic [AW-1:0] raddr;
	logic [PW-1:0] rsum;

	bstate_t state_q, state_d;
	phase_t  ph_q, ph_d;
	logic [PW-1:0] cnt_q, cnt_d, pos_q, pos_d, lim_q, lim_d, flen_q, flen_d;
	logic [2:0]    n_q, n_d, kind_q, kind_d;
	logic [15:0]   crc_q, crc_d, tag_q, tag_d;
	logic [31:0]   acc_q, acc_d, flags_q, flags_d;
	logic [3:0]    ind_q, ind_d, idx_q, idx_d;
	logic          src_q, src_d;
	ftype_t        ft_q, ft_d;
	logic signed [15:0] last_x_q, last_x_d, last_y_q, last_y_d;
	result_t       pend_q, pend_d, er;
	logic          pend_v_q, pend_v_d, em, go;

	function automatic result_t mk_field(input logic s, input logic [4:0] code,
	                                     input logic [3:0] i, input logic [31:0] v);
		result_t r;
		r = '0;
		r.kind       = K_FIELD;
		r.source     = s;
		r.field_code = code;
		r.item_index = i;
		r.value      = v;
		return r;
	endfunction

	assign rsum  = pos_q + cnt_q;
	assign raddr = (state_q == B_CRC) ? cnt_q[AW-1:0] : rsum[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	always_comb begin
		state_d = state_q; ph_d = ph_q; cnt_d = cnt_q; pos_d = pos_q; lim_d = lim_q;
		flen_d = flen_q; n_d = n_q; kind_d = kind_q; crc_d = crc_q; tag_d = tag_q;
		acc_d = acc_q; flags_d = flags_q; ind_d = ind_q; idx_d = idx_q; src_d = src_q;
		ft_d = ft_q; last_x_d = last_x_q; last_y_d = last_y_q;
		pend_d = pend_q; pend_v_d = pend_v_q;
		em = 1'b0; er = '0; job_take = 1'b0;
		go = !(pend_v_q && fifo_full);
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					job_take = 1'b1;
					src_d    = 1'b0;
					if (job.jk == J_FRAME) begin
						crc_d   = 16'hFFFF;
						cnt_d   = '0;
						flen_d  = job.flen;
						ft_d    = job.ft;
						state_d = B_CRC;
					end else begin
						case (job.jk)
							J_START: kind_d = K_START;
							J_STOP:  kind_d = K_STOP;
							default: kind_d = K_LONG;
						endcase
						ph_d    = P_SIMPLE;
						state_d = B_PLAN;
					end
				end
			end
			B_CRC: begin
				if (cnt_q != '0) begin
					crc_d = crc_byte(crc_q, rdata_q);
				end
				if (cnt_q == flen_q - PW'(2)) begin
					pos_d   = flen_q - PW'(2);
					lim_d   = flen_q;
					n_d     = 3'd2;
					cnt_d   = '0;
					ph_d    = P_CRCV;
					state_d = B_FETCH;
				end else begin
					cnt_d = cnt_q + PW'(1);
				end
			end
			B_FETCH: begin
				if (cnt_q == '0 && ({1'b0, pos_q} + (PW+1)'(n_q)) > {1'b0, lim_q}) begin
					ph_d    = P_TRUNC;
					state_d = B_PLAN;
				end else begin
					acc_d = (cnt_q == '0) ? '0 : {acc_q[23:0], rdata_q};
					if (cnt_q == PW'(n_q)) begin
						pos_d   = pos_q + PW'(n_q);
						state_d = B_USE;
					end else begin
						cnt_d = cnt_q + PW'(1);
					end
				end
			end
			B_PLAN: begin
				if (go) begin
					cnt_d = '0;
					case (ph_q)
						P_SIMPLE: begin
							em = 1'b1; er.kind = kind_q; state_d = B_FLUSH;
						end
						P_TRUNC: begin
							em = 1'b1; er.kind = K_TRUNC; er.source = src_q; state_d = B_FLUSH;
						end
						A_IND, A_TAG, T_IND, T_FLAGS, A_XYZ, T_XYZ, A_DIAG, T_STAT: begin
							n_d = 3'd2; state_d = B_FETCH;
						end
						A_FLAGS, A_STAMP: begin
							n_d = 3'd4; state_d = B_FETCH;
						end
						A_POS: begin
							if (ind_q[0] && flags_q[16]) begin
								ph_d = A_XYZ; idx_d = '0;
							end else begin
								if (ind_q[0]) pos_d = pos_q + PW'(6);
								ph_d = A_DSEC;
							end
						end
						A_DSEC: begin
							idx_d = '0;
							ph_d  = ind_q[1] ? A_DIST : A_GSEC;
						end
						A_DIST: begin
							if (flags_q[{1'b0, idx_q}]) begin
								n_d = 3'd2; state_d = B_FETCH;
							end else begin
								pos_d = pos_q + PW'(2);
								em    = 1'b1;
								er    = mk_field(src_q, F_DIST, idx_q, '0);
								if (idx_q == 4'(ANCHOR_COUNT - 1)) ph_d = A_GSEC;
								else idx_d = idx_q + 4'd1;
							end
						end
						A_GSEC: begin
							idx_d = '0;
							if (ind_q[2] && tag_q == watched_tag_id) begin
								ph_d = A_DIAG;
							end else begin
								if (ind_q[2]) pos_d = pos_q + PW'(16);
								ph_d = A_SSEC;
							end
						end
						A_SSEC: begin
							idx_d = '0;
							if (ind_q[3] && tag_q == watched_tag_id) ph_d = A_STAMP;
							else state_d = B_FLUSH;
						end
						T_FSEC: begin
							if (ind_q[0]) ph_d = T_FLAGS;
							else ph_d = T_PSEC;
						end
						T_DIST: begin
							if (flags_q[{1'b0, idx_q}]) begin
								n_d = 3'd2; state_d = B_FETCH;
							end else begin
								pos_d = pos_q + PW'(2);
								if (idx_q == 4'(ANCHOR_COUNT - 1)) ph_d = T_PSEC;
								else idx_d = idx_q + 4'd1;
							end
						end
						T_PSEC: begin
							if (ind_q[1]) ph_d = T_STAT;
							else state_d = B_FLUSH;
						end
						T_REP: begin
							em = 1'b1; er.kind = K_POS; er.source = 1'b1;
							er.report_x = last_x_q; er.report_y = last_y_q;
							state_d = B_FLUSH;
						end
						default: state_d = B_FLUSH;
					endcase
				end
			end
			B_USE: begin
				if (go) begin
					state_d = B_PLAN;
					case (ph_q)
						P_CRCV: begin
							if (acc_q[15:8] == crc_q[7:0] && acc_q[7:0] == crc_q[15:8]) begin
								pos_d = PW'(5);
								lim_d = flen_q - PW'(2);
								case (ft_q)
									FT_ANCHOR: begin ph_d = A_IND; src_d = 1'b0; end
									FT_TAG:    begin ph_d = T_IND; src_d = 1'b1; end
									default:   state_d = B_FLUSH;
								endcase
							end else begin
								em = 1'b1; er.kind = K_CRC; state_d = B_FLUSH;
							end
						end
						A_IND: begin
							ind_d = acc_q[3:0]; em = 1'b1;
							er = mk_field(src_q, F_IND, '0, acc_q); ph_d = A_TAG;
						end
						A_TAG: begin
							tag_d = acc_q[15:0]; em = 1'b1;
							er = mk_field(src_q, F_TAG, '0, acc_q); ph_d = A_FLAGS;
						end
						A_FLAGS: begin
							flags_d = acc_q; em = 1'b1;
							er = mk_field(src_q, F_STATUS, '0, acc_q); ph_d = A_POS;
						end
						A_XYZ, T_XYZ: begin
							if (idx_q == 4'd0) last_x_d = acc_q[15:0];
							if (idx_q == 4'd1) last_y_d = acc_q[15:0];
							em = 1'b1;
							er = mk_field(src_q, F_X + {1'b0, idx_q}, '0, acc_q);
							if (idx_q == 4'd2) ph_d = (ph_q == A_XYZ) ? A_DSEC : T_REP;
							else idx_d = idx_q + 4'd1;
						end
						A_DIST, T_DIST: begin
							em = 1'b1;
							er = mk_field(src_q, F_DIST, idx_q, acc_q);
							if (idx_q == 4'(ANCHOR_COUNT - 1)) ph_d = (ph_q == A_DIST) ? A_GSEC : T_PSEC;
							else idx_d = idx_q + 4'd1;
						end
						A_DIAG: begin
							em = 1'b1;
							er = mk_field(src_q, F_DIAG + {1'b0, idx_q}, '0,
							              (idx_q == 4'd7) ? (acc_q >> 6) : acc_q);
							if (idx_q == 4'd7) ph_d = A_SSEC;
							else idx_d = idx_q + 4'd1;
						end
						A_STAMP: begin
							em = 1'b1;
							er = mk_field(src_q, F_STAMP, idx_q, acc_q);
							if (idx_q == 4'(STAMP_COUNT - 1)) state_d = B_FLUSH;
							else idx_d = idx_q + 4'd1;
						end
						T_IND: begin
							ind_d = acc_q[3:0]; em = 1'b1;
							er = mk_field(src_q, F_IND, '0, acc_q); ph_d = T_FSEC;
						end
						T_FLAGS: begin
							flags_d = {16'h0000, acc_q[15:0]}; idx_d = '0; em = 1'b1;
							er = mk_field(src_q, F_DFLAGS, '0, acc_q); ph_d = T_DIST;
						end
						T_STAT: begin
							em = 1'b1; idx_d = '0;
							er = mk_field(src_q, F_STATUS, '0, acc_q);
							ph_d = (acc_q == 32'd1) ? T_XYZ : T_REP;
						end
						default: state_d = B_FLUSH;
					endcase
				end
			end
			B_FLUSH: begin
				if (go) begin
					pend_v_d = 1'b0;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
		if (em) begin
			pend_d   = er;
			pend_v_d = 1'b1;
		end
		res_push = pend_v_q && go && (em || state_q == B_FLUSH);
		res      = pend_q;
		res.last = (state_q == B_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			ph_q     <= P_SIMPLE;
			pend_v_q <= 1'b0;
			last_x_q <= '0;
			last_y_q <= '0;
			cnt_q <= '0; pos_q <= '0; lim_q <= '0; flen_q <= '0; n_q <= '0; kind_q <= '0;
			crc_q <= '0; tag_q <= '0; acc_q <= '0; flags_q <= '0; ind_q <= '0; idx_q <= '0;
			src_q <= 1'b0; ft_q <= FT_NONE; pend_q <= '0;
		end else begin
			state_q  <= state_d;
			ph_q     <= ph_d;
			pend_v_q <= pend_v_d;
			last_x_q <= last_x_d;
			last_y_q <= last_y_d;
			cnt_q <= cnt_d; pos_q <= pos_d; lim_q <= lim_d; flen_q <= flen_d; n_q <= n_d;
			kind_q <= kind_d; crc_q <= crc_d; tag_q <= tag_d; acc_q <= acc_d;
			flags_q <= flags_d; ind_q <= ind_d; idx_q <= idx_d; src_q <= src_d;
			ft_q <= ft_d; pend_q <= pend_d;
		end
	end

	assign busy = (state_q != B_IDLE);

endmodule

FILE: design/mlfr_fifo.sv
// Result queue between the decode sequencer and the output ports.
`timescale 1ns / 1ps
module mlfr_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mlfr_pkg::result_t din,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output mlfr_pkg::result_t dout
);
	import mlfr_pkg::*;

	localparam int QW = $clog2(RQ_DEPTH);

	result_t        ent_q [RQ_DEPTH];
	logic [QW-1:0]  wp_q, rp_q;
	logic [QW:0]    cnt_q;
	logic           do_push, do_pop;

	assign full    = (cnt_q == (QW+1)'(RQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + QW'(1);
			if (do_pop)  rp_q <= rp_q + QW'(1);
			cnt_q <= cnt_q + (QW+1)'(do_push) - (QW+1)'(do_pop);
		end
	end

endmodule

FILE: design/modbus_location_frame_receiver.sv
// Top level of the location frame receiver: front end, decode back end, result queue.
//  channel   | direction | handshake            | payload
//  rx bytes  | in        | push / full          | rx_byte
//  config    | in        | cfg_we               | watched_tag_id
//  results   | out       | empty / pop          | kind .. last
// A byte that completes nothing leaves full low; full rises for the job it starts.
// A frame job takes the job and runs the CRC (one memory read per byte), then fetches
// and checks the CRC bytes; each field is then fetched byte by byte and used, with
// a decision step in B_PLAN for each section.
// full stays high while the back end works; a full result queue stalls the back end.
// Reset clears fill count, queue and stored coordinates; the frame memory is not cleared.
`timescale 1ns / 1ps
module modbus_location_frame_receiver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_we,
	input  logic [15:0]        watched_tag_id,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         kind,
	output logic               source,
	output logic [4:0]         field_code,
	output logic [3:0]         item_index,
	output logic [31:0]        value,
	output logic signed [15:0] report_x,
	output logic signed [15:0] report_y,
	output logic               last
);
	import mlfr_pkg::*;

	logic [15:0] watched_q;
	wr_t         wr;
	logic        job_valid, job_take, busy, res_push, q_full;
	job_t        job;
	result_t     res, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watched_q <= '0;
		end else if (cfg_we) begin
			watched_q <= watched_tag_id;
		end
	end

	assign full = job_valid || busy;

	mlfr_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(push && !full), .rx_byte(rx_byte),
		.job_take(job_take), .wr(wr), .job_valid(job_valid), .job(job)
	);

	mlfr_back u_back (
		.clk(clk), .arst_n(arst_n), .wr(wr), .job_valid(job_valid), .job(job),
		.watched_tag_id(watched_q), .fifo_full(q_full), .job_take(job_take),
		.busy(busy), .res_push(res_push), .res(res)
	);

	mlfr_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(res_push), .din(res), .pop(pop),
		.full(q_full), .empty(empty), .dout(head)
	);

	assign kind       = head.kind;
	assign source     = head.source;
	assign field_code = head.field_code;
	assign item_index = head.item_index;
	assign value      = head.value;
	assign report_x   = head.report_x;
	assign report_y   = head.report_y;
	assign last       = head.last;

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == K_START || kind == K_STOP || kind == K_LONG || kind == K_CRC))
		|-> last)
		else $error("single result without last");

	a_report_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != K_POS) |-> (report_x == 16'sd0 && report_y == 16'sd0))
		else $error("coordinates outside position report");

	a_field_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != K_FIELD) |-> (field_code == 5'd0 && value == 32'd0))
		else $error("field data outside field result");

endmodule
